[design/mtfal_pkg.sv]
`default_nettype none
package mtfal_pkg;

  // Fixed widths of the request, result and configuration fields.
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned OPND_W = 32;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned CFG_W  = 11;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Control part of one queued command; the operand travels beside it.
  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] index;
  } cmd_t;

endpackage
`default_nettype wire

[design/mtfal_front.sv]
`default_nettype none
module mtfal_front #(
  parameter int unsigned LEAVES     = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               req_type_i,
  input  wire logic [mtfal_pkg::IDX_W-1:0]        entry_index_i,
  input  wire logic signed [mtfal_pkg::OPND_W-1:0] operand_value_i,
  input  wire logic [((($clog2(LEAVES) + 1) > mtfal_pkg::CFG_W) ?
                      ($clog2(LEAVES) + 1) : mtfal_pkg::CFG_W)-1:0] cfg_count_i,
  input  wire logic                               clearing_i,
  input  wire logic                               q_full_i,
  output logic [((($clog2(LEAVES) + 1) > mtfal_pkg::CFG_W) ?
                 ($clog2(LEAVES) + 1) : mtfal_pkg::CFG_W)-1:0] act_count_o,
  output logic                                    push_o,
  output mtfal_pkg::cmd_t                         cmd_o,
  output logic [((VALUE_BITS > mtfal_pkg::OPND_W) ?
                 VALUE_BITS : mtfal_pkg::OPND_W)-1:0] value_o
);
  import mtfal_pkg::*;

  localparam int unsigned LEAF_W = $clog2(LEAVES);
  localparam int unsigned CNT_W  = ((LEAF_W + 1) > CFG_W) ? (LEAF_W + 1) : CFG_W;
  localparam int unsigned CMP_W  = (VALUE_BITS > OPND_W) ? VALUE_BITS : OPND_W;

  localparam logic signed [CMP_W-1:0] MinC =
    {{(CMP_W - VALUE_BITS + 1){1'b1}}, {(VALUE_BITS - 1){1'b0}}};
  localparam logic signed [CMP_W-1:0] MaxC =
    {{(CMP_W - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};

  logic                    accept;
  logic                    drop;
  logic signed [CMP_W-1:0] opnd_ext;
  logic signed [CMP_W-1:0] opnd_sat;

  // The count in use is the register saturated to the table size.
  assign act_count_o = (cfg_count_i > CNT_W'(LEAVES)) ? CNT_W'(LEAVES) : cfg_count_i;

  assign in_stall_o = clearing_i | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Writes outside the active range leave the table untouched, so they are
  // consumed here and never reach the tree engine.
  assign drop = (op_e'(req_type_i) == OP_WRITE) &&
                (CNT_W'(entry_index_i) >= act_count_o);

  assign opnd_ext = CMP_W'(operand_value_i);
  assign opnd_sat = (opnd_ext > MaxC) ? MaxC : ((opnd_ext < MinC) ? MinC : opnd_ext);

  assign push_o       = accept & ~drop;
  assign cmd_o.op     = op_e'(req_type_i);
  assign cmd_o.index  = entry_index_i;
  // Write values are clamped to the stored range; thresholds keep full precision.
  assign value_o      = (op_e'(req_type_i) == OP_WRITE) ? opnd_sat : opnd_ext;

endmodule
`default_nettype wire

[design/mtfal_queue.sv]
`default_nettype none
module mtfal_queue #(
  parameter int unsigned VAL_W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire mtfal_pkg::cmd_t   push_cmd_i,
  input  wire logic [VAL_W-1:0]  push_value_i,
  output logic                   full_o,
  output logic                   valid_o,
  output mtfal_pkg::cmd_t        cmd_o,
  output logic [VAL_W-1:0]       value_o,
  input  wire logic              pop_i
);
  import mtfal_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             cmd_q   [QUEUE_DEPTH];
  logic [VAL_W-1:0] value_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = cmd_q[rd_ptr_q];
  assign value_o = value_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      cmd_q[wr_ptr_q]   <= push_cmd_i;
      value_q[wr_ptr_q] <= push_value_i;
    end
  end

endmodule
`default_nettype wire

[design/mtfal_back.sv]
`default_nettype none
module mtfal_back #(
  parameter int unsigned LEAVES     = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [((($clog2(LEAVES) + 1) > mtfal_pkg::CFG_W) ?
                      ($clog2(LEAVES) + 1) : mtfal_pkg::CFG_W)-1:0] act_count_i,
  input  wire logic                         q_valid_i,
  input  wire mtfal_pkg::cmd_t              q_cmd_i,
  input  wire logic [((VALUE_BITS > mtfal_pkg::OPND_W) ?
                      VALUE_BITS : mtfal_pkg::OPND_W)-1:0] q_value_i,
  output logic                              q_pop_o,
  output logic                              clearing_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              found_o,
  output logic [mtfal_pkg::POS_W-1:0]       position_o
);
  import mtfal_pkg::*;

  localparam int unsigned LEAF_W = $clog2(LEAVES);
  localparam int unsigned ADDR_W = LEAF_W + 1;
  localparam int unsigned DEPTH  = 2 ** ADDR_W;
  localparam int unsigned CNT_W  = ((LEAF_W + 1) > CFG_W) ? (LEAF_W + 1) : CFG_W;
  localparam int unsigned CMP_W  = (VALUE_BITS > OPND_W) ? VALUE_BITS : OPND_W;

  localparam logic [VALUE_BITS-1:0] MinV = {1'b1, {(VALUE_BITS - 1){1'b0}}};

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_UP    = 5'b00100,
    ST_ROOT  = 5'b01000,
    ST_DOWN  = 5'b10000
  } state_e;

  // Heap-ordered tree: node 1 is the root, leaves sit at 2**LEAF_W + index.
  logic [VALUE_BITS-1:0] mem [DEPTH];

  state_e                st_q, st_d;
  logic [ADDR_W-1:0]     node_q, node_d;
  logic [ADDR_W-1:0]     clr_q, clr_d;
  logic [VALUE_BITS-1:0] carry_q, carry_d;
  logic [CMP_W-1:0]      thr_q, thr_d;
  logic [VALUE_BITS-1:0] rd_q;
  logic                  res_valid_q;
  logic                  found_q;
  logic [POS_W-1:0]      pos_q;

  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [ADDR_W-1:0]     raddr;
  logic                  res_set;
  logic                  res_found;
  logic [POS_W-1:0]      res_pos;
  logic [ADDR_W-1:0]     leaf_addr;
  logic [ADDR_W-1:0]     parent;
  logic [ADDR_W-1:0]     next_node;
  logic [VALUE_BITS-1:0] up_max;
  logic                  rd_ge;
  logic                  leaf_hit;

  assign leaf_addr = {1'b1, LEAF_W'(q_cmd_i.index)};
  assign parent    = node_q >> 1;
  assign up_max    = ($signed(rd_q) > $signed(carry_q)) ? rd_q : carry_q;
  assign rd_ge     = $signed(CMP_W'($signed(rd_q))) >= $signed(thr_q);
  // Step to the left child when it meets the threshold, else to the right one.
  assign next_node = {node_q[ADDR_W-2:0], ~rd_ge};
  assign leaf_hit  = CNT_W'(next_node[LEAF_W-1:0]) < act_count_i;

  always_comb begin
    st_d      = st_q;
    node_d    = node_q;
    clr_d     = clr_q;
    carry_d   = carry_q;
    thr_d     = thr_q;
    we        = 1'b0;
    waddr     = '0;
    wdata     = carry_q;
    raddr     = '0;
    q_pop_o   = 1'b0;
    res_set   = 1'b0;
    res_found = 1'b0;
    res_pos   = '0;
    case (st_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = MinV;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i && (q_cmd_i.op == OP_WRITE || !res_valid_q)) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.op)
            OP_WRITE: begin
              we      = 1'b1;
              waddr   = leaf_addr;
              wdata   = q_value_i[VALUE_BITS-1:0];
              carry_d = q_value_i[VALUE_BITS-1:0];
              node_d  = leaf_addr;
              raddr   = leaf_addr ^ ADDR_W'(1);
              st_d    = ST_UP;
            end
            OP_QUERY: begin
              thr_d = q_value_i;
              if (act_count_i == '0) begin
                res_set = 1'b1;
              end else begin
                raddr = ADDR_W'(1);
                st_d  = ST_ROOT;
              end
            end
            default: begin
              st_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_UP: begin
        // rd_q holds the sibling of node_q; the other child is the carried maximum.
        we      = 1'b1;
        waddr   = parent;
        wdata   = up_max;
        carry_d = up_max;
        node_d  = parent;
        raddr   = parent ^ ADDR_W'(1);
        if (parent == ADDR_W'(1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (rd_ge) begin
          node_d = ADDR_W'(1);
          raddr  = ADDR_W'(2);
          st_d   = ST_DOWN;
        end else begin
          res_set = 1'b1;
          st_d    = ST_IDLE;
        end
      end
      ST_DOWN: begin
        node_d = next_node;
        if (next_node[ADDR_W-1]) begin
          res_set   = 1'b1;
          res_found = leaf_hit;
          res_pos   = leaf_hit ? POS_W'(next_node[LEAF_W-1:0]) : '0;
          st_d      = ST_IDLE;
        end else begin
          raddr = {next_node[ADDR_W-2:0], 1'b0};
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      clr_q <= clr_d;
      if (res_set) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    carry_q <= carry_d;
    thr_q   <= thr_d;
    if (res_set) begin
      found_q <= res_found;
      pos_q   <= res_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  assign clearing_o  = (st_q == ST_CLEAR);
  assign out_valid_o = res_valid_q;
  assign found_o     = found_q;
  assign position_o  = pos_q;

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_CLEAR |-> !q_pop_o)
    else $error("command taken during the clearing pass");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && found_q |-> CNT_W'(pos_q) < act_count_i)
    else $error("reported position lies outside the active count");

  a_miss_reports_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !found_q |-> pos_q == '0)
    else $error("miss reported with a nonzero position");

  a_climb_below_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_UP |-> node_q[ADDR_W-1:1] != '0)
    else $error("update climb started from the root");

endmodule
`default_nettype wire

[design/max_tree_first_at_least.sv]
// Max tree with first-index-at-least search.
//
// Requests enter on the input channel (in_valid_i, in_stall_o) and carry
// req_type_i, entry_index_i and operand_value_i. A write request stores one
// entry and gives no result; a write at or beyond the active count is dropped.
// A query request gives exactly one result on the output channel
// (out_valid_o, out_stall_i): found_o and the lowest matching position_o.
// The user must write the element count register (cfg_we_i / cfg_wdata_i)
// only while the block is idle, which the block does not enforce; values
// above LEAVES are used as LEAVES.
// A write stores the leaf and climbs level by level to the root, writing
// each parent with the larger of its children. A query reads the root and,
// if it meets the threshold, descends level by level to the leftmost leaf
// that does; an empty table or a root below the threshold gives no match.
// The single read port of the tree memory sets this level-by-level pace. A
// two-entry queue lets new requests be taken while the engine works. After
// reset the tree memory is swept to the minimum value, and in_stall_o
// stays high meanwhile. A stalled result holds in the output register;
// the engine takes no new query until it is delivered; writes still proceed.
`default_nettype none
module max_tree_first_at_least #(
  parameter int unsigned LEAVES     = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [mtfal_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                req_type_i,
  input  wire logic [mtfal_pkg::IDX_W-1:0]         entry_index_i,
  input  wire logic signed [mtfal_pkg::OPND_W-1:0] operand_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     found_o,
  output logic [mtfal_pkg::POS_W-1:0]              position_o
);
  import mtfal_pkg::*;

  localparam int unsigned LEAF_W = $clog2(LEAVES);
  localparam int unsigned CNT_W  = ((LEAF_W + 1) > CFG_W) ? (LEAF_W + 1) : CFG_W;
  localparam int unsigned CMP_W  = (VALUE_BITS > OPND_W) ? VALUE_BITS : OPND_W;

  // Element count register; it resets to the full table size.
  logic [CNT_W-1:0] cfg_count_q;
  logic [CNT_W-1:0] act_count;

  // Front to queue.
  logic             push;
  cmd_t             push_cmd;
  logic [CMP_W-1:0] push_value;
  logic             q_full;

  // Queue to back.
  logic             q_valid;
  cmd_t             q_cmd;
  logic [CMP_W-1:0] q_value;
  logic             q_pop;
  logic             clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q <= CNT_W'(LEAVES);
    end else if (cfg_we_i) begin
      cfg_count_q <= CNT_W'(cfg_wdata_i);
    end
  end

  // The front classifies each request: dropped writes end here, valid writes
  // are clamped to the stored value range, and queries pass their threshold.
  mtfal_front #(
    .LEAVES     (LEAVES),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .entry_index_i   (entry_index_i),
    .operand_value_i (operand_value_i),
    .cfg_count_i     (cfg_count_q),
    .clearing_i      (clearing),
    .q_full_i        (q_full),
    .act_count_o     (act_count),
    .push_o          (push),
    .cmd_o           (push_cmd),
    .value_o         (push_value)
  );

  mtfal_queue #(
    .VAL_W (CMP_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .push_value_i (push_value),
    .full_o       (q_full),
    .valid_o      (q_valid),
    .cmd_o        (q_cmd),
    .value_o      (q_value),
    .pop_i        (q_pop)
  );

  // The back owns the tree memory: it climbs the tree for writes, descends
  // it for queries and holds each result in its output register.
  mtfal_back #(
    .LEAVES     (LEAVES),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .act_count_i (act_count),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_value_i   (q_value),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .position_o  (position_o)
  );

endmodule
`default_nettype wire
